FILE: hdl/eic_pkg.sv
// ----------------------------------------------------------------------------
// eic_pkg
// Types, constants and helper functions for the Ethernet/IPv4/TCP/UDP
// classifier core.
// ----------------------------------------------------------------------------
package eic_pkg;

  localparam int unsigned POS_W      = 17;
  localparam logic [POS_W-1:0] MAX_FRAME = 17'd65549;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] FOLD_ONES  = 16'hffff;
  localparam logic [3:0]  MIN_WORDS  = 4'd5;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 152;

  // Byte offsets inside the frame.
  localparam logic [POS_W-1:0] POS_TYPE_HI  = 17'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LO  = 17'd13;
  localparam logic [POS_W-1:0] POS_IP_START = 17'd14;
  localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd16;
  localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd17;
  localparam logic [POS_W-1:0] POS_PROTO    = 17'd23;
  localparam logic [POS_W-1:0] POS_ADDR_LO  = 17'd26;
  localparam logic [POS_W-1:0] POS_ADDR_HI  = 17'd33;

  typedef enum logic [1:0] {
    CLS_NOT_IPV4 = 2'd0,
    CLS_TCP      = 2'd1,
    CLS_UDP      = 2'd2,
    CLS_OTHER    = 2'd3
  } pkt_class_t;

  // Frame state captured at the final byte.
  typedef struct packed {
    logic [POS_W-1:0] flen;
    logic             is_ipv4;
    logic [3:0]       ip_hdr_words;
    logic [15:0]      ip_total_len;
    logic [7:0]       ip_proto;
    logic [3:0]       tcp_hdr_words;
    logic [15:0]      ones_sum;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
  } frame_snap_t;

  // Result item, last member in the lowest bits.
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] other_total;
    logic [31:0] udp_total;
    logic [31:0] tcp_total;
    logic        truncated;
    logic [15:0] payload_len;
    logic        checksum_ok;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    pkt_class_t  pkt_class;
  } result_t;

  function automatic logic [15:0] fold16(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [3:0] eff_words(input logic [3:0] w);
    return (w < MIN_WORDS) ? MIN_WORDS : w;
  endfunction

endpackage

FILE: hdl/eth_ipv4_tcp_udp_classifier_core.sv
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_udp_classifier_core
// Parses an Ethernet frame byte by byte, classifies it as non-IPv4 or as IPv4 TCP,
// UDP or other, extracts ports, checks the TCP checksum and keeps counts of TCP, UDP and other IPv4 frames.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per clock cycle while s_tready is high.
// A frame's final byte passes through the input register and the frame snapshot;
// its result is then written into the output buffer.
// A two-entry output buffer decouples the sides; s_tready drops only when it
// is full. Reset (rst, synchronous) clears frame state, counters and valids.
module eth_ipv4_tcp_udp_classifier_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata    // pkt_class, src_port, dst_port, checksum_ok,
                                  // payload_len, truncated, tcp_total, udp_total,
                                  // other_total, zero pad
);
  import eic_pkg::*;

  logic en;

  // Input register.
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;

  // Per-frame state.
  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [15:0]      ether_kind, ether_kind_next;
  logic [3:0]       ip_hdr_words, ip_hdr_words_next;
  logic [15:0]      ip_total_len, ip_total_len_next;
  logic [7:0]       ip_proto, ip_proto_next;
  logic [3:0]       tcp_hdr_words, tcp_hdr_words_next;
  logic [15:0]      ones_sum, ones_sum_next;
  logic [7:0]       high_byte_hold, high_byte_hold_next;
  logic [15:0]      port_src_reg, port_src_reg_next;
  logic [15:0]      port_dst_reg, port_dst_reg_next;

  logic [POS_W-1:0] l4_pos, seg_end, k_pos;
  logic             l4ports, in_l4, in_seg;

  // Snapshot stage.
  logic        snap_valid;
  frame_snap_t snap;

  // Counters and result.
  logic [31:0] tcp_count, tcp_count_next;
  logic [31:0] udp_count, udp_count_next;
  logic [31:0] other_count, other_count_next;
  result_t     res;

  logic [7:0]       ihl4, thl4, l4_len, need_tcp, need_udp, hdr_tcp;
  logic [POS_W-1:0] total_end, udp_diff;
  logic [15:0]      s1, s2;
  logic             short_frame, len_ok;

  // Output buffer.
  logic    main_valid, skid_valid, push, pop;
  result_t main_q, skid_q;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign m_tvalid = main_valid;
  assign m_tdata  = main_q;
  assign push     = en && snap_valid;
  assign pop      = main_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_tvalid;
    end
    if (en) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_comb begin
    byte_pos_next       = byte_pos;
    ether_kind_next     = ether_kind;
    ip_hdr_words_next   = ip_hdr_words;
    ip_total_len_next   = ip_total_len;
    ip_proto_next       = ip_proto;
    tcp_hdr_words_next  = tcp_hdr_words;
    ones_sum_next       = ones_sum;
    high_byte_hold_next = high_byte_hold;
    port_src_reg_next   = port_src_reg;
    port_dst_reg_next   = port_dst_reg;

    l4_pos  = POS_IP_START + {11'd0, eff_words(ip_hdr_words), 2'b00};
    seg_end = POS_IP_START + {1'b0, ip_total_len};
    k_pos   = byte_pos - l4_pos;
    l4ports = (ip_proto == PROTO_TCP) || (ip_proto == PROTO_UDP);
    in_l4   = (byte_pos >= l4_pos) && (byte_pos < l4_pos + 17'd4);
    in_seg  = (ip_proto == PROTO_TCP) && (byte_pos >= l4_pos) && (byte_pos < seg_end);

    if (byte_pos < MAX_FRAME) begin
      byte_pos_next = byte_pos + 17'd1;
      if (byte_pos == POS_TYPE_HI) begin
        ether_kind_next = {in_data, 8'h00};
      end else if (byte_pos == POS_TYPE_LO) begin
        ether_kind_next = {ether_kind[15:8], in_data};
      end
      if (ether_kind == ETHERTYPE_IPV4 && byte_pos >= POS_IP_START) begin
        if (byte_pos == POS_IP_START) begin
          ip_hdr_words_next = in_data[3:0];
        end else if (byte_pos == POS_LEN_HI) begin
          ip_total_len_next = {in_data, 8'h00};
        end else if (byte_pos == POS_LEN_LO) begin
          ip_total_len_next = {ip_total_len[15:8], in_data};
        end else if (byte_pos == POS_PROTO) begin
          ip_proto_next = in_data;
        end
        if (byte_pos >= POS_ADDR_LO && byte_pos <= POS_ADDR_HI) begin
          if (!byte_pos[0]) begin
            high_byte_hold_next = in_data;
          end else begin
            ones_sum_next = fold16(ones_sum, {high_byte_hold, in_data});
          end
        end
        if (l4ports && in_l4) begin
          case (k_pos[1:0])
            2'd0:    port_src_reg_next = {in_data, port_src_reg[7:0]};
            2'd1:    port_src_reg_next = {port_src_reg[15:8], in_data};
            2'd2:    port_dst_reg_next = {in_data, port_dst_reg[7:0]};
            default: port_dst_reg_next = {port_dst_reg[15:8], in_data};
          endcase
        end
        if (in_seg) begin
          if (byte_pos == l4_pos + 17'd12) begin
            tcp_hdr_words_next = in_data[7:4];
          end
          if (!byte_pos[0]) begin
            if (byte_pos + 17'd1 == seg_end) begin
              ones_sum_next = fold16(ones_sum, {in_data, 8'h00});
            end else begin
              high_byte_hold_next = in_data;
            end
          end else begin
            ones_sum_next = fold16(ones_sum, {high_byte_hold, in_data});
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos       <= '0;
      ether_kind     <= '0;
      ip_hdr_words   <= '0;
      ip_total_len   <= '0;
      ip_proto       <= '0;
      tcp_hdr_words  <= '0;
      ones_sum       <= '0;
      high_byte_hold <= '0;
      port_src_reg   <= '0;
      port_dst_reg   <= '0;
      snap_valid     <= 1'b0;
    end else if (en) begin
      snap_valid <= in_valid && in_last;
      if (in_valid) begin
        if (in_last) begin
          byte_pos       <= '0;
          ether_kind     <= '0;
          ip_hdr_words   <= '0;
          ip_total_len   <= '0;
          ip_proto       <= '0;
          tcp_hdr_words  <= '0;
          ones_sum       <= '0;
          high_byte_hold <= '0;
          port_src_reg   <= '0;
          port_dst_reg   <= '0;
        end else begin
          byte_pos       <= byte_pos_next;
          ether_kind     <= ether_kind_next;
          ip_hdr_words   <= ip_hdr_words_next;
          ip_total_len   <= ip_total_len_next;
          ip_proto       <= ip_proto_next;
          tcp_hdr_words  <= tcp_hdr_words_next;
          ones_sum       <= ones_sum_next;
          high_byte_hold <= high_byte_hold_next;
          port_src_reg   <= port_src_reg_next;
          port_dst_reg   <= port_dst_reg_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snap.flen          <= byte_pos_next;
      snap.is_ipv4       <= (ether_kind_next == ETHERTYPE_IPV4);
      snap.ip_hdr_words  <= ip_hdr_words_next;
      snap.ip_total_len  <= ip_total_len_next;
      snap.ip_proto      <= ip_proto_next;
      snap.tcp_hdr_words <= tcp_hdr_words_next;
      snap.ones_sum      <= ones_sum_next;
      snap.src_port      <= port_src_reg_next;
      snap.dst_port      <= port_dst_reg_next;
    end
  end

  always_comb begin
    ihl4        = {2'b00, eff_words(snap.ip_hdr_words), 2'b00};
    thl4        = {2'b00, eff_words(snap.tcp_hdr_words), 2'b00};
    l4_len      = 8'd14 + ihl4;
    need_tcp    = l4_len + thl4;
    need_udp    = l4_len + 8'd8;
    hdr_tcp     = ihl4 + thl4;
    total_end   = POS_IP_START + {1'b0, snap.ip_total_len};
    udp_diff    = snap.flen - {9'd0, need_udp};
    short_frame = snap.flen < POS_IP_START;
    len_ok      = snap.ip_total_len >= {8'd0, hdr_tcp};
    s1          = fold16(snap.ones_sum, 16'd6);
    s2          = fold16(s1, snap.ip_total_len - {8'd0, ihl4});

    res             = '0;
    res.pkt_class   = CLS_NOT_IPV4;
    res.truncated   = short_frame;
    if (!short_frame && snap.is_ipv4) begin
      if (snap.ip_proto == PROTO_TCP) begin
        res.pkt_class   = CLS_TCP;
        res.truncated   = (snap.flen < {9'd0, need_tcp}) || (snap.flen < total_end);
        res.payload_len = len_ok ? (snap.ip_total_len - {8'd0, hdr_tcp}) : 16'd0;
        res.src_port    = snap.src_port;
        res.dst_port    = snap.dst_port;
        res.checksum_ok = !res.truncated && len_ok && (s2 == FOLD_ONES);
      end else if (snap.ip_proto == PROTO_UDP) begin
        res.pkt_class   = CLS_UDP;
        res.truncated   = (snap.flen < {9'd0, need_udp}) || (snap.flen < total_end);
        if (snap.flen <= {9'd0, need_udp}) begin
          res.payload_len = 16'd0;
        end else if (udp_diff[16]) begin
          res.payload_len = 16'hffff;
        end else begin
          res.payload_len = udp_diff[15:0];
        end
        res.src_port    = snap.src_port;
        res.dst_port    = snap.dst_port;
      end else begin
        res.pkt_class   = CLS_OTHER;
        res.truncated   = (snap.flen < {9'd0, l4_len}) || (snap.flen < total_end);
        res.payload_len = (snap.ip_total_len > {8'd0, ihl4}) ?
                          (snap.ip_total_len - {8'd0, ihl4}) : 16'd0;
      end
    end

    tcp_count_next   = tcp_count;
    udp_count_next   = udp_count;
    other_count_next = other_count;
    if (res.pkt_class == CLS_TCP && tcp_count != '1) begin
      tcp_count_next = tcp_count + 32'd1;
    end
    if (res.pkt_class == CLS_UDP && udp_count != '1) begin
      udp_count_next = udp_count + 32'd1;
    end
    if (res.pkt_class == CLS_OTHER && other_count != '1) begin
      other_count_next = other_count + 32'd1;
    end
    res.tcp_total   = tcp_count_next;
    res.udp_total   = udp_count_next;
    res.other_total = other_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tcp_count   <= '0;
      udp_count   <= '0;
      other_count <= '0;
    end else if (push) begin
      tcp_count   <= tcp_count_next;
      udp_count   <= udp_count_next;
      other_count <= other_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main_q <= skid_q;
    end else if (push && (pop || !main_valid)) begin
      main_q <= res;
    end
    if (push && main_valid && !pop) begin
      skid_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("Skid entry is occupied while the main output entry is empty.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("Input is stalled although no result is waiting.");

  a_tcp_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> tcp_count >= $past(tcp_count))
    else $error("TCP frame count decreased.");

  a_no_push_when_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_tready |=> $stable(tcp_count) && $stable(udp_count))
    else $error("Counters changed while the output buffer was full.");
`endif

endmodule

FILE: tb/eth_ipv4_tcp_udp_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// Ethernet/IPv4/TCP/UDP classifier core testbench
// Streams whole frames one byte per transaction into the classifier. A
// built-in frame model computes each expected frame summary, and every
// summary that leaves the core is compared field by field against it.
// Directed frames cover short, non-IPv4, small and large IHL and data offset,
// odd segments, bad checksums, bad lengths and truncation.
// Random frames follow, mostly well-formed with some noise, under three
// settings of source and sink stalls.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_udp_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eic_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;   // [7:0] data_byte
  logic         s_tlast = 1'b0;    // last_byte
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;           // pkt_class, src_port, dst_port, checksum_ok,
                                   // payload_len, truncated, tcp_total, udp_total,
                                   // other_total, zero pad

  int          send_idle_pct = 27;
  int          recv_idle_pct = 56;
  int          bytes_sent = 0;
  logic [7:0]  frame_bytes[$];

  eth_ipv4_tcp_udp_classifier_core u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  class frame_summary_tracker;
    logic [16:0] pos;
    logic [15:0] ether_kind;
    logic [3:0]  ihl_w;
    logic [3:0]  doff_w;
    logic [15:0] ip_len;
    logic [15:0] csum_acc;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [7:0]  hi_hold;
    logic [31:0] n_tcp;
    logic [31:0] n_udp;
    logic [31:0] n_other;
    result_t     pending[$];
    int          errors;
    int          frames;
    int          csum_good;
    int          truncs;
    int          per_class[4];

    function new();
      n_tcp = '0;
      n_udp = '0;
      n_other = '0;
      errors = 0;
      frames = 0;
      csum_good = 0;
      truncs = 0;
      foreach (per_class[i]) per_class[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = '0;
      ether_kind = '0;
      ihl_w = '0;
      doff_w = '0;
      ip_len = '0;
      csum_acc = '0;
      sport = '0;
      dport = '0;
      proto = '0;
      hi_hold = '0;
    endfunction

    function int unsigned hdr_bytes(logic [3:0] w);
      return (w < MIN_WORDS) ? 4 * int'(MIN_WORDS) : 4 * int'(w);
    endfunction

    function logic [15:0] clamp_diff(int unsigned a, int unsigned b);
      if (a <= b) return 16'd0;
      return (a - b > 65535) ? 16'hffff : 16'(a - b);
    endfunction

    function void absorb(int unsigned p, logic [7:0] b);
      int unsigned l4;
      int unsigned seg_end;
      int unsigned k;
      bit          l4ports;
      l4 = 14 + hdr_bytes(ihl_w);
      seg_end = 14 + ip_len;
      l4ports = (proto == PROTO_TCP) || (proto == PROTO_UDP);
      if (p == POS_TYPE_HI) ether_kind = {b, 8'h00};
      else if (p == POS_TYPE_LO) ether_kind[7:0] = b;
      if (ether_kind != ETHERTYPE_IPV4 || p < POS_IP_START) return;
      if (p == POS_IP_START) ihl_w = b[3:0];
      else if (p == POS_LEN_HI) ip_len = {b, 8'h00};
      else if (p == POS_LEN_LO) ip_len[7:0] = b;
      else if (p == POS_PROTO) proto = b;
      if (p >= POS_ADDR_LO && p <= POS_ADDR_HI) begin
        if (p % 2 == 0) hi_hold = b;
        else csum_acc = ones_add(csum_acc, {hi_hold, b});
      end
      if (l4ports && p >= l4 && p < l4 + 4) begin
        k = p - l4;
        case (k)
          0: sport[15:8] = b;
          1: sport[7:0] = b;
          2: dport[15:8] = b;
          default: dport[7:0] = b;
        endcase
      end
      if (proto == PROTO_TCP && p >= l4 && p < seg_end) begin
        if (p == l4 + 12) doff_w = b[7:4];
        if (p % 2 == 0) begin
          if (p + 1 == seg_end) csum_acc = ones_add(csum_acc, {b, 8'h00});
          else hi_hold = b;
        end else begin
          csum_acc = ones_add(csum_acc, {hi_hold, b});
        end
      end
    endfunction

    function void note_byte(logic [7:0] d, logic last);
      int unsigned flen;
      int unsigned ihl4;
      int unsigned thl4;
      int unsigned need;
      logic [15:0] s;
      result_t     r;
      if (pos < MAX_FRAME) begin
        absorb(pos, d);
        pos = pos + 1'b1;
      end
      if (!last) return;
      flen = pos;
      ihl4 = hdr_bytes(ihl_w);
      thl4 = hdr_bytes(doff_w);
      r = '0;
      r.pkt_class = CLS_NOT_IPV4;
      if (flen < 14 || ether_kind != ETHERTYPE_IPV4) begin
        r.truncated = (flen < 14);
      end else begin
        if (proto == PROTO_TCP) begin
          r.pkt_class = CLS_TCP;
          need = 14 + ihl4 + thl4;
          r.payload_len = clamp_diff(ip_len, ihl4 + thl4);
        end else if (proto == PROTO_UDP) begin
          r.pkt_class = CLS_UDP;
          need = 14 + ihl4 + 8;
          r.payload_len = clamp_diff(flen, 14 + ihl4 + 8);
        end else begin
          r.pkt_class = CLS_OTHER;
          need = 14 + ihl4;
          r.payload_len = clamp_diff(ip_len, ihl4);
        end
        r.truncated = (flen < need) || (flen < 14 + ip_len);
        if (r.pkt_class != CLS_OTHER) begin
          r.src_port = sport;
          r.dst_port = dport;
        end
        if (r.pkt_class == CLS_TCP && !r.truncated && ip_len >= ihl4 + thl4) begin
          s = ones_add(csum_acc, {8'h00, PROTO_TCP});
          s = ones_add(s, 16'(ip_len - ihl4));
          r.checksum_ok = (s == FOLD_ONES);
        end
      end
      if (r.pkt_class == CLS_TCP && n_tcp != '1) n_tcp = n_tcp + 1;
      if (r.pkt_class == CLS_UDP && n_udp != '1) n_udp = n_udp + 1;
      if (r.pkt_class == CLS_OTHER && n_other != '1) n_other = n_other + 1;
      r.tcp_total = n_tcp;
      r.udp_total = n_udp;
      r.other_total = n_other;
      pending.push_back(r);
      frames++;
      per_class[r.pkt_class]++;
      if (r.checksum_ok) csum_good++;
      if (r.truncated) truncs++;
      clear_frame();
    endfunction

    function void compare(string fname, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, e, a);
        errors++;
      end
    endfunction

    function void check_summary(logic [151:0] bits);
      result_t got;
      result_t exp;
      got = result_t'(bits);
      if (pending.size() == 0) begin
        $display("%0t ns: unexpected summary, expected none, actual %h", $time, bits);
        errors++;
        return;
      end
      exp = pending.pop_front();
      compare("pkt_class", exp.pkt_class, got.pkt_class);
      compare("src_port", exp.src_port, got.src_port);
      compare("dst_port", exp.dst_port, got.dst_port);
      compare("checksum_ok", exp.checksum_ok, got.checksum_ok);
      compare("payload_len", exp.payload_len, got.payload_len);
      compare("truncated", exp.truncated, got.truncated);
      compare("tcp_total", exp.tcp_total, got.tcp_total);
      compare("udp_total", exp.udp_total, got.udp_total);
      compare("other_total", exp.other_total, got.other_total);
    endfunction
  endclass

  frame_summary_tracker sb = new();

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) sb.check_summary(m_tdata);
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= l;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic build_raw(input int len, input logic [15:0] etype);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
    if (len > 13) begin
      frame_bytes[12] = etype[15:8];
      frame_bytes[13] = etype[7:0];
    end
  endtask

  task automatic build_fill(input int len, input logic [7:0] v);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(v);
  endtask

  task automatic build_ip(input logic [7:0] proto_v, input logic [3:0] ihl_f,
                          input logic [3:0] doff_f, input int pay_len,
                          input int len_adj, input bit fix_csum);
    int          ihl4;
    int          l4hdr;
    int          total;
    int          l4;
    int          stop;
    logic [15:0] acc;
    logic [7:0]  lo;
    ihl4 = (ihl_f < MIN_WORDS) ? 4 * int'(MIN_WORDS) : 4 * int'(ihl_f);
    if (proto_v == PROTO_TCP)
      l4hdr = (doff_f < MIN_WORDS) ? 4 * int'(MIN_WORDS) : 4 * int'(doff_f);
    else if (proto_v == PROTO_UDP) l4hdr = 8;
    else l4hdr = 0;
    total = ihl4 + l4hdr + pay_len + len_adj;
    if (total < 0) total = 0;
    if (total > 65535) total = 65535;
    l4 = 14 + ihl4;
    build_raw(l4 + l4hdr + pay_len, ETHERTYPE_IPV4);
    frame_bytes[14] = {4'h4, ihl_f};
    frame_bytes[16] = total[15:8];
    frame_bytes[17] = total[7:0];
    frame_bytes[23] = proto_v;
    if (proto_v == PROTO_TCP) begin
      frame_bytes[l4 + 12] = {doff_f, frame_bytes[l4 + 12][3:0]};
      frame_bytes[l4 + 16] = 8'h00;
      frame_bytes[l4 + 17] = 8'h00;
      if (fix_csum && total >= ihl4 + l4hdr) begin
        acc = 16'h0000;
        for (int i = 26; i < 34; i += 2) acc = ones_add(acc, {frame_bytes[i], frame_bytes[i + 1]});
        acc = ones_add(acc, {8'h00, PROTO_TCP});
        acc = ones_add(acc, 16'(total - ihl4));
        stop = 14 + total;
        if (stop > frame_bytes.size()) stop = frame_bytes.size();
        for (int i = l4; i < stop; i += 2) begin
          lo = (i + 1 < stop) ? frame_bytes[i + 1] : 8'h00;
          acc = ones_add(acc, {frame_bytes[i], lo});
        end
        frame_bytes[l4 + 16] = ~acc[15:8];
        frame_bytes[l4 + 17] = ~acc[7:0];
      end
    end
  endtask

  task automatic corrupt_byte();
    int idx;
    idx = $urandom_range(frame_bytes.size() - 1, 26);
    frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(255, 1));
  endtask

  task automatic cut_frame(input int keep);
    while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
  endtask

  function automatic logic [3:0] pick_words();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 4'd5;
    if (r < 90) return 4'($urandom_range(8, 6));
    if (r < 96) return 4'($urandom_range(4, 0));
    return 4'($urandom_range(15, 9));
  endfunction

  task automatic random_frame();
    int         kind;
    int         pay;
    int         adj;
    logic [7:0] pr;
    logic [15:0] et;
    kind = $urandom_range(99);
    pay = ($urandom_range(99) < 75) ? $urandom_range(12, 0) : $urandom_range(80, 13);
    adj = ($urandom_range(3) == 0) ? int'($urandom_range(20, 0)) - 10 : 0;
    if (kind < 35) begin
      build_ip(PROTO_TCP, pick_words(), pick_words(), pay, 0, 1'b1);
    end else if (kind < 43) begin
      build_ip(PROTO_TCP, pick_words(), pick_words(), pay, int'($urandom_range(40, 0)) - 30, 1'b1);
      if ($urandom_range(1)) corrupt_byte();
    end else if (kind < 63) begin
      build_ip(PROTO_UDP, pick_words(), 4'd0, pay, adj, 1'b0);
    end else if (kind < 73) begin
      pr = 8'($urandom_range(255));
      build_ip(pr, pick_words(), 4'd0, pay, adj, 1'b0);
    end else if (kind < 83) begin
      case ($urandom_range(3))
        0: et = 16'h0801;
        1: et = 16'h0008;
        2: et = 16'h86dd;
        default: et = 16'($urandom_range(65535));
      endcase
      build_raw(14 + $urandom_range(56), et);
    end else if (kind < 88) begin
      build_raw($urandom_range(13, 1), ETHERTYPE_IPV4);
    end else begin
      build_ip($urandom_range(1) ? PROTO_TCP : PROTO_UDP, pick_words(), pick_words(), pay, 0, 1'b1);
      cut_frame($urandom_range(frame_bytes.size() - 1, 1));
    end
    send_frame();
  endtask

  task automatic random_phase(input int src_pct, input int dst_pct);
    int start_bytes;
    send_idle_pct = src_pct;
    recv_idle_pct = dst_pct;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 30) random_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    build_raw(1, 16'h0000);
    send_frame();
    build_raw(13, 16'h0000);
    send_frame();
    build_raw(14, ETHERTYPE_IPV4);
    send_frame();
    build_ip(PROTO_TCP, 4'd5, 4'd5, 0, 0, 1'b1);
    cut_frame(20);
    send_frame();
    build_raw(20, 16'h86dd);
    send_frame();
    build_fill(20, 8'hff);
    send_frame();
    build_fill(20, 8'h00);
    send_frame();
    build_ip(PROTO_TCP, 4'd5, 4'd5, 0, 0, 1'b1);
    send_frame();
    build_ip(PROTO_TCP, 4'd5, 4'd5, 7, 0, 1'b1);
    send_frame();
    build_ip(PROTO_TCP, 4'd6, 4'd8, 10, 0, 1'b1);
    send_frame();
    build_ip(PROTO_TCP, 4'd0, 4'd0, 3, 0, 1'b1);
    send_frame();
    build_ip(PROTO_TCP, 4'd15, 4'd15, 1, 0, 1'b1);
    send_frame();
    build_ip(PROTO_TCP, 4'd5, 4'd5, 6, 0, 1'b1);
    corrupt_byte();
    send_frame();
    build_ip(PROTO_TCP, 4'd5, 4'd5, 4, -30, 1'b1);
    send_frame();
    build_ip(PROTO_TCP, 4'd5, 4'd6, 9, 0, 1'b1);
    cut_frame(50);
    send_frame();
    build_ip(PROTO_UDP, 4'd5, 4'd0, 0, 0, 1'b0);
    send_frame();
    build_ip(PROTO_UDP, 4'd7, 4'd0, 5, 0, 1'b0);
    send_frame();
    build_ip(PROTO_UDP, 4'd5, 4'd0, 9, -9, 1'b0);
    send_frame();
    build_ip(8'd1, 4'd5, 4'd0, 8, 0, 1'b0);
    send_frame();
    build_ip(8'd255, 4'd5, 4'd0, 0, 0, 1'b0);
    send_frame();
    build_ip(8'd0, 4'd5, 4'd0, 4, -100, 1'b0);
    send_frame();

    random_phase(27, 56);
    random_phase(56, 27);
    random_phase(0, 0);
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d frames in %0d bytes: %0d non-IPv4, %0d TCP, %0d UDP, %0d other IP.",
             sb.frames, bytes_sent, sb.per_class[CLS_NOT_IPV4], sb.per_class[CLS_TCP],
             sb.per_class[CLS_UDP], sb.per_class[CLS_OTHER]);
    $display("%0d valid TCP checksums, %0d truncated frames, %0d mismatches.",
             sb.csum_good, sb.truncs, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d summaries outstanding.", sb.pending.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/eic_pkg.sv
hdl/eth_ipv4_tcp_udp_classifier_core.sv
tb/eth_ipv4_tcp_udp_classifier_core_tb.sv
